### src/psq_pkg.sv
// Shared kind codes, function codes and a helper function for the paired-single quantizer.
`timescale 1ns / 1ps

package psq_pkg;

    localparam logic [2:0] KIND_F32 = 3'd0;
    localparam logic [2:0] KIND_U8  = 3'd4;
    localparam logic [2:0] KIND_U16 = 3'd5;
    localparam logic [2:0] KIND_S8  = 3'd6;
    localparam logic [2:0] KIND_S16 = 3'd7;

    localparam logic FUNC_DEQUANT = 1'b0;
    localparam logic FUNC_QUANT   = 1'b1;

    // Highest set bit of a 23-bit vector (0 when the vector is zero).
    function automatic logic [4:0] lead_one(input logic [22:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (v[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

### src/paired_single_quantizer.sv
// Top level: load/store conversion between raw words and IEEE doubles.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, func, operand, kind,  | into block
//          | shift_amount                              |
//  output  | out_valid, out_ready, converted           | out of block
//
// One beat is taken per cycle while in_ready is high. A beat lands in the input register
// when it is accepted and the conversion runs combinationally into the result register,
// which loads when the output can advance and then offers the result on converted.
// Reset (rst_n low) empties both stages.
// A stalled output holds its result; the input register keeps filling while
// the result register can advance, so the pipe only stalls when both are full.
`timescale 1ns / 1ps

module paired_single_quantizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] operand,
    input  logic [2:0]  kind,
    input  logic [4:0]  shift_amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] converted
);

    // Pipeline registers.
    logic        s1_valid_reg;
    logic        func_reg;
    logic [63:0] operand_reg;
    logic [2:0]  kind_reg;
    logic [4:0]  shift_reg;
    logic        out_valid_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    logic out_adv;
    logic s1_adv;

    // Advance the result register whenever it is empty or being drained.
    assign out_adv  = !out_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || out_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            func_reg    <= func;
            operand_reg <= operand;
            kind_reg    <= kind;
            shift_reg   <= shift_amount;
        end
        if (out_adv && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign converted = result_reg;

    // ------------------------------------------------------------------
    // Dequantize: single to double widening.
    // ------------------------------------------------------------------
    logic        ws_sign;
    logic [7:0]  ws_exp;
    logic [22:0] ws_frac;
    logic [4:0]  ws_lead;
    logic [22:0] ws_norm;
    logic [63:0] widen_res;

    assign ws_sign = operand_reg[31];
    assign ws_exp  = operand_reg[30:23];
    assign ws_frac = operand_reg[22:0];
    assign ws_lead = psq_pkg::lead_one(ws_frac);
    assign ws_norm = ws_frac << (5'd22 - ws_lead);

    always_comb
    begin
        if (ws_exp == 8'hFF)
        begin
            if (ws_frac != 23'd0)
            begin
                // NaN: keep payload, force quiet.
                widen_res = {ws_sign, 11'h7FF, 1'b1, ws_frac[21:0], 29'd0};
            end
            else
            begin
                widen_res = {ws_sign, 11'h7FF, 52'd0};
            end
        end
        else if (ws_exp == 8'd0)
        begin
            if (ws_frac == 23'd0)
            begin
                widen_res = {ws_sign, 63'd0};
            end
            else
            begin
                // Denormal single: normalize around the leading one.
                widen_res = {ws_sign, 11'd874 + 11'(ws_lead), ws_norm[21:0], 30'd0};
            end
        end
        else
        begin
            widen_res = {ws_sign, 11'(ws_exp) + 11'd896, ws_frac, 29'd0};
        end
    end

    // ------------------------------------------------------------------
    // Dequantize: integer to double, scaled by 2^-shift.
    // ------------------------------------------------------------------
    logic        di_neg;
    logic [15:0] di_mag;
    logic [4:0]  di_lead;
    logic [15:0] di_norm;
    logic [63:0] int_res;

    always_comb
    begin
        di_neg = 1'b0;
        di_mag = 16'd0;
        case (kind_reg)
            psq_pkg::KIND_U8:  di_mag = {8'd0, operand_reg[7:0]};
            psq_pkg::KIND_U16: di_mag = operand_reg[15:0];
            psq_pkg::KIND_S8:
            begin
                di_neg = operand_reg[7];
                di_mag = operand_reg[7] ? 16'(-{8'hFF, operand_reg[7:0]})
                                        : {8'd0, operand_reg[7:0]};
            end
            psq_pkg::KIND_S16:
            begin
                di_neg = operand_reg[15];
                di_mag = operand_reg[15] ? 16'(-operand_reg[15:0]) : operand_reg[15:0];
            end
            default: di_mag = 16'd0;
        endcase
    end

    assign di_lead = psq_pkg::lead_one({7'd0, di_mag});
    assign di_norm = di_mag << (5'd15 - di_lead);

    always_comb
    begin
        if (di_mag == 16'd0)
        begin
            int_res = 64'd0;
        end
        else
        begin
            int_res = {di_neg, 11'd1023 + 11'(di_lead) - 11'(shift_reg),
                       di_norm[14:0], 37'd0};
        end
    end

    // ------------------------------------------------------------------
    // Quantize: double to single, round to nearest even.
    // ------------------------------------------------------------------
    logic         nd_sign;
    logic [10:0]  nd_exp;
    logic [51:0]  nd_frac;
    logic [22:0]  nd_keep;
    logic         nd_guard;
    logic         nd_sticky;
    logic [30:0]  nd_norm_sum;
    logic [5:0]   nd_shift;
    logic [107:0] nd_wide;
    logic [23:0]  nd_m;
    logic         nd_dguard;
    logic         nd_dsticky;
    logic [30:0]  nd_den_sum;
    logic [31:0]  narrow_res;

    assign nd_sign  = operand_reg[63];
    assign nd_exp   = operand_reg[62:52];
    assign nd_frac  = operand_reg[51:0];
    assign nd_keep  = nd_frac[51:29];
    assign nd_guard = nd_frac[28];
    assign nd_sticky = |nd_frac[27:0];
    // A rounding carry runs into the exponent, and into infinity at the top.
    assign nd_norm_sum = {8'(nd_exp - 11'd896), nd_keep}
                       + 31'(nd_guard && (nd_sticky || nd_keep[0]));

    assign nd_shift   = 6'(11'd926 - nd_exp);
    assign nd_wide    = {1'b1, nd_frac, 55'd0} >> nd_shift;
    assign nd_m       = nd_wide[78:55];
    assign nd_dguard  = nd_wide[54];
    assign nd_dsticky = |nd_wide[53:0];
    assign nd_den_sum = {7'd0, nd_m} + 31'(nd_dguard && (nd_dsticky || nd_m[0]));

    always_comb
    begin
        if (nd_exp == 11'h7FF)
        begin
            if (nd_frac != 52'd0)
            begin
                narrow_res = {nd_sign, 8'hFF, 1'b1, nd_frac[50:29]};
            end
            else
            begin
                narrow_res = {nd_sign, 8'hFF, 23'd0};
            end
        end
        else if (nd_exp > 11'd1150)
        begin
            narrow_res = {nd_sign, 8'hFF, 23'd0};
        end
        else if (nd_exp >= 11'd897)
        begin
            narrow_res = {nd_sign, nd_norm_sum};
        end
        else if (nd_exp >= 11'd872)
        begin
            narrow_res = {nd_sign, nd_den_sum};
        end
        else
        begin
            narrow_res = {nd_sign, 31'd0};
        end
    end

    // ------------------------------------------------------------------
    // Quantize: double scaled by 2^shift, clamped and truncated.
    // ------------------------------------------------------------------
    logic        qi_sign;
    logic        qi_nan;
    logic        qi_inf;
    logic [12:0] qi_e;
    logic        qi_sat;
    logic [15:0] qi_mag;
    logic [16:0] qi_limit;
    logic [16:0] qi_clip;
    logic [16:0] qi_val;
    logic        qi_signed;
    logic [31:0] quant_res;

    assign qi_sign = operand_reg[63];
    assign qi_nan  = (nd_exp == 11'h7FF) && (nd_frac != 52'd0);
    assign qi_inf  = (nd_exp == 11'h7FF) && (nd_frac == 52'd0);
    assign qi_e    = 13'(nd_exp) - 13'd1023 + 13'(shift_reg);
    assign qi_sat  = !qi_e[12] && (qi_e >= 13'd16);
    assign qi_mag  = qi_e[12] ? 16'd0
                   : ({1'b1, nd_frac[51:37]} >> (4'd15 - qi_e[3:0]));
    assign qi_signed = (kind_reg == psq_pkg::KIND_S8) || (kind_reg == psq_pkg::KIND_S16);

    always_comb
    begin
        case (kind_reg)
            psq_pkg::KIND_U8:  qi_limit = 17'd255;
            psq_pkg::KIND_U16: qi_limit = 17'd65535;
            psq_pkg::KIND_S8:  qi_limit = (qi_sign && !qi_nan) ? 17'd128 : 17'd127;
            psq_pkg::KIND_S16: qi_limit = (qi_sign && !qi_nan) ? 17'd32768 : 17'd32767;
            default:           qi_limit = 17'd0;
        endcase
    end

    always_comb
    begin
        if (qi_nan || qi_inf || qi_sat || ({1'b0, qi_mag} > qi_limit))
        begin
            qi_clip = qi_limit;
        end
        else
        begin
            qi_clip = {1'b0, qi_mag};
        end
        if (qi_nan)
        begin
            qi_val = qi_limit;
        end
        else if (qi_sign && !qi_signed)
        begin
            // Negative values clamp to zero for unsigned kinds.
            qi_val = 17'd0;
        end
        else if (qi_sign)
        begin
            qi_val = 17'(-qi_clip);
        end
        else
        begin
            qi_val = qi_clip;
        end
        case (kind_reg)
            psq_pkg::KIND_U8:  quant_res = {24'd0, qi_val[7:0]};
            psq_pkg::KIND_U16: quant_res = {16'd0, qi_val[15:0]};
            psq_pkg::KIND_S8:  quant_res = {24'd0, qi_val[7:0]};
            psq_pkg::KIND_S16: quant_res = {16'd0, qi_val[15:0]};
            default:           quant_res = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Result select.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (func_reg == psq_pkg::FUNC_QUANT)
        begin
            result_next = (kind_reg == psq_pkg::KIND_F32) ? {32'd0, narrow_res}
                                                          : {32'd0, quant_res};
        end
        else
        begin
            result_next = (kind_reg == psq_pkg::KIND_F32) ? widen_res : int_res;
        end
    end

endmodule
